// ----- hw/rtl/rgbblit_pkg.sv -----
// Shared widths, codes and interface types of the RGB frame blit engine.
`timescale 1ns / 1ps
package rgbblit_pkg;

  localparam int REQ_W   = 3;
  localparam int POS_W   = 12;
  localparam int RW_W    = 11;
  localparam int RH_W    = 10;
  localparam int PIX_W   = 24;
  localparam int ST_W    = 2;
  localparam int CW      = POS_W + 1;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = RW_W;

  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 512;

  localparam logic [RW_W-1:0] FRAME_WIDTH_RST  = RW_W'(640);
  localparam logic [RH_W-1:0] FRAME_HEIGHT_RST = RH_W'(480);

  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = CFG_IDX_W'(1);

  typedef enum logic [REQ_W-1:0] {
    REQ_WRITE     = 3'd0,
    REQ_READ      = 3'd1,
    REQ_COPY      = 3'd2,
    REQ_SWAP      = 3'd3,
    REQ_MIRROR_TB = 3'd4,
    REQ_MIRROR_LR = 3'd5
  } req_e;

  typedef enum logic [ST_W-1:0] {
    ST_OK     = 2'd0,
    ST_RANGE  = 2'd1,
    ST_HALTED = 2'd2
  } st_e;

  typedef enum logic [1:0] {
    WSEL_PIX    = 2'd0,
    WSEL_A_TO_B = 2'd1,
    WSEL_B_TO_A = 2'd2
  } wsel_e;

  typedef struct packed {
    logic  latch;
    logic  calc;
    logic  rd;
    logic  wr;
    wsel_e wsel;
    logic  advance;
    logic  load_out;
    st_e   out_status;
    logic  out_pix;
  } cmd_t;

  typedef struct packed {
    logic empty;
    logic last;
    logic ok_a;
    logic ok_b;
  } sts_t;

endpackage

// ----- hw/rtl/rgbblit_ram.sv -----
// Frame store: one write port, two registered read ports.
`timescale 1ns / 1ps
module rgbblit_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 24
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_a_i,
  input  logic [AW-1:0] raddr_b_i,
  output logic [DW-1:0] rdata_a_o,
  output logic [DW-1:0] rdata_b_o
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Read data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_a_o <= mem[raddr_a_i];
      rdata_b_o <= mem[raddr_b_i];
    end
  end

endmodule

// ----- hw/rtl/rgbblit_dp.sv -----
// Datapath: configuration, pixel walk counters, address generation and frame store.
`timescale 1ns / 1ps
module rgbblit_dp #(
  parameter int MAX_WIDTH  = rgbblit_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbblit_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [rgbblit_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgbblit_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input  logic [rgbblit_pkg::REQ_W-1:0]      req_type_i,
  input  logic [rgbblit_pkg::POS_W-1:0]      src_x_i,
  input  logic [rgbblit_pkg::POS_W-1:0]      src_y_i,
  input  logic [rgbblit_pkg::RW_W-1:0]       rect_width_i,
  input  logic [rgbblit_pkg::RH_W-1:0]       rect_height_i,
  input  logic [rgbblit_pkg::POS_W-1:0]      dst_x_i,
  input  logic [rgbblit_pkg::POS_W-1:0]      dst_y_i,
  input  logic [rgbblit_pkg::PIX_W-1:0]      pixel_in_i,
  input  rgbblit_pkg::cmd_t                  cmd_i,
  output rgbblit_pkg::sts_t                  sts_o,
  output logic [rgbblit_pkg::ST_W-1:0]       status_o,
  output logic [rgbblit_pkg::PIX_W-1:0]      pixel_out_o
);
  import rgbblit_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int LW    = RH_W + RW_W + 1;

  logic [RW_W-1:0]  fw_q;
  logic [RH_W-1:0]  fh_q;
  logic [RW_W-1:0]  ew;
  logic [RH_W-1:0]  eh;

  req_e             req_q;
  logic [POS_W-1:0] sx_q, sy_q, dx_q, dy_q;
  logic [PIX_W-1:0] pix_q;
  logic [RW_W-1:0]  outer_q, inner_q, i_q, j_q;
  logic [RW_W-1:0]  outer_d, inner_d;

  logic [CW-1:0]    ax, ay, bx, by;
  logic             ok_a, ok_b;
  logic [LW-2:0]    prod_a, prod_b;
  logic [LW-1:0]    lin_a, lin_b;
  logic [AW-1:0]    addr_a_q, addr_b_q;
  logic             ok_a_q, ok_b_q;

  logic             we;
  logic [AW-1:0]    waddr;
  logic [PIX_W-1:0] wdata;
  logic [PIX_W-1:0] rdata_a, rdata_b;

  logic [ST_W-1:0]  res_st_q;
  logic [PIX_W-1:0] res_pix_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q <= FRAME_WIDTH_RST;
      fh_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_FRAME_WIDTH:  fw_q <= cfg_data_i;
        CFG_FRAME_HEIGHT: fh_q <= cfg_data_i[RH_W-1:0];
        default: ;
      endcase
    end
  end

  // Saturate the frame size to the store dimensions.
  assign ew = ({2'b00, fw_q} > 13'(MAX_WIDTH))  ? RW_W'(MAX_WIDTH)  : fw_q;
  assign eh = ({3'b000, fh_q} > 13'(MAX_HEIGHT)) ? RH_W'(MAX_HEIGHT) : fh_q;

  always_comb begin
    case (req_e'(req_type_i)) inside
      REQ_COPY, REQ_SWAP: begin
        outer_d = rect_width_i;
        inner_d = {1'b0, rect_height_i};
      end
      REQ_MIRROR_TB: begin
        outer_d = ew;
        inner_d = {2'b00, eh[RH_W-1:1]};
      end
      REQ_MIRROR_LR: begin
        outer_d = {1'b0, eh};
        inner_d = {1'b0, ew[RW_W-1:1]};
      end
      default: begin
        outer_d = RW_W'(1);
        inner_d = RW_W'(1);
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      req_q   <= req_e'(req_type_i);
      sx_q    <= src_x_i;
      sy_q    <= src_y_i;
      dx_q    <= dst_x_i;
      dy_q    <= dst_y_i;
      pix_q   <= pixel_in_i;
      outer_q <= outer_d;
      inner_q <= inner_d;
    end
  end

  // Inner index runs fastest; wrap it and step the outer one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.latch) begin
      i_q <= '0;
      j_q <= '0;
    end else if (cmd_i.advance) begin
      if (j_q + RW_W'(1) == inner_q) begin
        j_q <= '0;
        i_q <= i_q + RW_W'(1);
      end else begin
        j_q <= j_q + RW_W'(1);
      end
    end
  end

  assign sts_o.empty = (outer_q == '0) || (inner_q == '0);
  assign sts_o.last  = ({1'b0, j_q} + 12'd1 == {1'b0, inner_q}) &&
                       ({1'b0, i_q} + 12'd1 == {1'b0, outer_q});
  assign sts_o.ok_a  = ok_a_q;
  assign sts_o.ok_b  = ok_b_q;

  always_comb begin
    case (req_q) inside
      REQ_MIRROR_TB: begin
        ax = {2'b00, i_q};
        ay = {2'b00, j_q};
        bx = {2'b00, i_q};
        by = {3'b000, eh} - CW'(1) - {2'b00, j_q};
      end
      REQ_MIRROR_LR: begin
        ax = {2'b00, j_q};
        ay = {2'b00, i_q};
        bx = {2'b00, ew} - CW'(1) - {2'b00, j_q};
        by = {2'b00, i_q};
      end
      default: begin
        ax = {sx_q[POS_W-1], sx_q} + {2'b00, i_q};
        ay = {sy_q[POS_W-1], sy_q} + {2'b00, j_q};
        bx = {dx_q[POS_W-1], dx_q} + {2'b00, i_q};
        by = {dy_q[POS_W-1], dy_q} + {2'b00, j_q};
      end
    endcase
  end

  assign ok_a = !ax[CW-1] && (ax[CW-2:0] < {1'b0, ew}) &&
                !ay[CW-1] && (ay[CW-2:0] < {2'b00, eh});
  assign ok_b = !bx[CW-1] && (bx[CW-2:0] < {1'b0, ew}) &&
                !by[CW-1] && (by[CW-2:0] < {2'b00, eh});

  // Row-major index; only meaningful for coordinates inside the frame.
  assign prod_a = ay[RH_W-1:0] * ew;
  assign prod_b = by[RH_W-1:0] * ew;
  assign lin_a  = LW'(prod_a) + LW'(ax[RW_W-1:0]);
  assign lin_b  = LW'(prod_b) + LW'(bx[RW_W-1:0]);

  always_ff @(posedge clk_i) begin
    if (cmd_i.calc) begin
      addr_a_q <= AW'(lin_a);
      addr_b_q <= AW'(lin_b);
      ok_a_q   <= ok_a;
      ok_b_q   <= ok_b;
    end
  end

  always_comb begin
    we = cmd_i.wr;
    case (cmd_i.wsel)
      WSEL_A_TO_B: begin
        waddr = addr_b_q;
        wdata = rdata_a;
      end
      WSEL_B_TO_A: begin
        waddr = addr_a_q;
        wdata = rdata_b;
      end
      default: begin
        waddr = addr_a_q;
        wdata = pix_q;
      end
    endcase
  end

  rgbblit_ram #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .DW    (PIX_W)
  ) u_ram (
    .clk_i     (clk_i),
    .we_i      (we),
    .waddr_i   (waddr),
    .wdata_i   (wdata),
    .re_i      (cmd_i.rd),
    .raddr_a_i (addr_a_q),
    .raddr_b_i (addr_b_q),
    .rdata_a_o (rdata_a),
    .rdata_b_o (rdata_b)
  );

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      res_st_q  <= cmd_i.out_status;
      res_pix_q <= cmd_i.out_pix ? rdata_a : '0;
    end
  end

  assign status_o    = res_st_q;
  assign pixel_out_o = res_pix_q;

endmodule

// ----- hw/rtl/rgbblit_ctrl.sv -----
// Controller: command sequencing, halt flag and result handshake.
`timescale 1ns / 1ps
module rgbblit_ctrl (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic [rgbblit_pkg::REQ_W-1:0] req_type_i,
  output logic                         in_ready_o,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  input  rgbblit_pkg::sts_t             sts_i,
  output rgbblit_pkg::cmd_t             cmd_o
);
  import rgbblit_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_START,
    S_CALC,
    S_CHECK,
    S_WR_B,
    S_WR_A,
    S_RESULT
  } state_e;

  state_e state_q;
  req_e   req_q;
  st_e    status_q;
  logic   halted_q;
  logic   out_valid_q;
  logic   accept;
  logic   out_free;
  logic   pix_op;

  assign accept   = in_valid_i && (state_q == S_IDLE);
  assign out_free = !out_valid_q || out_ready_i;
  assign pix_op   = (req_q == REQ_WRITE) || (req_q == REQ_READ);

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.wsel       = WSEL_PIX;
    cmd_o.out_status = status_q;
    cmd_o.latch      = accept;
    case (state_q)
      S_CALC: cmd_o.calc = 1'b1;
      S_CHECK: begin
        if (pix_op) begin
          cmd_o.wr = sts_i.ok_a && (req_q == REQ_WRITE);
          cmd_o.rd = sts_i.ok_a && (req_q == REQ_READ);
        end else begin
          cmd_o.rd = sts_i.ok_a && sts_i.ok_b;
        end
      end
      S_WR_B: begin
        cmd_o.wr      = 1'b1;
        cmd_o.wsel    = WSEL_A_TO_B;
        cmd_o.advance = (req_q == REQ_COPY) && !sts_i.last;
      end
      S_WR_A: begin
        cmd_o.wr      = 1'b1;
        cmd_o.wsel    = WSEL_B_TO_A;
        cmd_o.advance = !sts_i.last;
      end
      S_RESULT: begin
        cmd_o.load_out = out_free;
        cmd_o.out_pix  = (req_q == REQ_READ) && (status_q == ST_OK);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      req_q       <= REQ_WRITE;
      status_q    <= ST_OK;
      halted_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.load_out) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (accept) begin
            req_q <= req_e'(req_type_i);
            case (req_e'(req_type_i)) inside
              REQ_WRITE, REQ_READ: state_q <= S_CALC;
              [REQ_COPY:REQ_MIRROR_LR]: begin
                if (halted_q) begin
                  status_q <= ST_HALTED;
                  state_q  <= S_RESULT;
                end else begin
                  state_q <= S_START;
                end
              end
              default: begin
                status_q <= ST_RANGE;
                state_q  <= S_RESULT;
              end
            endcase
          end
        end
        S_START: begin
          if (sts_i.empty) begin
            status_q <= ST_OK;
            state_q  <= S_RESULT;
          end else begin
            state_q <= S_CALC;
          end
        end
        S_CALC: state_q <= S_CHECK;
        S_CHECK: begin
          if (pix_op) begin
            status_q <= sts_i.ok_a ? ST_OK : ST_RANGE;
            state_q  <= S_RESULT;
          end else if (!(sts_i.ok_a && sts_i.ok_b)) begin
            // First pixel out of range: stop and latch the halt.
            halted_q <= 1'b1;
            status_q <= ST_RANGE;
            state_q  <= S_RESULT;
          end else begin
            state_q <= S_WR_B;
          end
        end
        S_WR_B: begin
          if (req_q != REQ_COPY) begin
            state_q <= S_WR_A;
          end else if (sts_i.last) begin
            status_q <= ST_OK;
            state_q  <= S_RESULT;
          end else begin
            state_q <= S_CALC;
          end
        end
        S_WR_A: begin
          if (sts_i.last) begin
            status_q <= ST_OK;
            state_q  <= S_RESULT;
          end else begin
            state_q <= S_CALC;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/rgb_frame_block_copy_swap_mirror_core.sv -----
// Top level of the RGB frame blit engine: controller plus datapath.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+------------------------------------
//  in      | input     | in_valid_i / in_ready_o    | req_type, src/dst corners, size, pixel
//  out     | output    | out_valid_o / out_ready_i  | status, pixel_out
//  cfg     | input     | cfg_we_i (no wait)         | cfg_idx_i, cfg_data_i
//
// A pixel write or read goes through S_CALC and S_CHECK to S_RESULT; refused commands
// go straight to S_RESULT and empty ones pass S_START first. Copy takes each pixel
// through S_CALC, S_CHECK and S_WR_B (address, read, write); swap and the mirrors add
// S_WR_A for the second write through the single write port of the frame store.
// Reset clears the controller and the halt flag, not the store, and sets the frame
// size to 640 by 480. One item runs at a time; a new beat is taken while a result waits.
`timescale 1ns / 1ps
module rgb_frame_block_copy_swap_mirror_core #(
  parameter int MAX_WIDTH  = rgbblit_pkg::MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = rgbblit_pkg::MAX_HEIGHT_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [rgbblit_pkg::REQ_W-1:0]      req_type_i,
  input  logic [rgbblit_pkg::POS_W-1:0]      src_x_i,
  input  logic [rgbblit_pkg::POS_W-1:0]      src_y_i,
  input  logic [rgbblit_pkg::RW_W-1:0]       rect_width_i,
  input  logic [rgbblit_pkg::RH_W-1:0]       rect_height_i,
  input  logic [rgbblit_pkg::POS_W-1:0]      dst_x_i,
  input  logic [rgbblit_pkg::POS_W-1:0]      dst_y_i,
  input  logic [rgbblit_pkg::PIX_W-1:0]      pixel_in_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic [rgbblit_pkg::ST_W-1:0]       status_o,
  output logic [rgbblit_pkg::PIX_W-1:0]      pixel_out_o,
  input  logic                              cfg_we_i,
  input  logic [rgbblit_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rgbblit_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rgbblit_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rgbblit_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .req_type_i  (req_type_i),
    .in_ready_o  (in_ready_o),
    .out_ready_i (out_ready_i),
    .out_valid_o (out_valid_o),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rgbblit_dp #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .req_type_i    (req_type_i),
    .src_x_i       (src_x_i),
    .src_y_i       (src_y_i),
    .rect_width_i  (rect_width_i),
    .rect_height_i (rect_height_i),
    .dst_x_i       (dst_x_i),
    .dst_y_i       (dst_y_i),
    .pixel_in_i    (pixel_in_i),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .status_o      (status_o),
    .pixel_out_o   (pixel_out_o)
  );

endmodule

// ----- hw/rtl/rgbblit_chk.sv -----
// Port-level checker for the blit engine, bound to the top level.
`timescale 1ns / 1ps
module rgbblit_chk (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_ready_o,
  input logic                              out_valid_o,
  input logic                              out_ready_i,
  input logic [rgbblit_pkg::ST_W-1:0]       status_o,
  input logic [rgbblit_pkg::PIX_W-1:0]      pixel_out_o
);
  import rgbblit_pkg::*;

  logic       in_acc, out_acc;
  logic [1:0] pend_q;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  // Count beats taken but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 2'd0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o) && $stable(pixel_out_o))
    else $error("result beat dropped or changed while stalled");

  a_err_zero_pix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != ST_OK) |-> pixel_out_o == '0)
    else $error("failed command returned a non-zero pixel");

  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> pend_q != 2'd0)
    else $error("result offered with no command outstanding");

  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |-> pend_q <= 2'd1)
    else $error("command taken while two are already outstanding");

endmodule

bind rgb_frame_block_copy_swap_mirror_core rgbblit_chk u_chk (.*);

// ----- test/tb.sv -----
// Self-checking bench for the RGB frame blit engine against a shadow frame store.
`timescale 1ns / 1ps
module tb;
  import rgbblit_pkg::*;

  localparam int STORE_DEPTH    = MAX_WIDTH_DEF * MAX_HEIGHT_DEF;
  localparam int IDLE_LIMIT     = 10000;
  localparam int RX_HOLD_CYCLES = 400;
  localparam int RAND_PHASES    = 9;
  localparam int OPS_PER_PHASE  = 80;

  localparam logic [REQ_W-1:0] REQ_BAD_LO = 3'd6;
  localparam logic [REQ_W-1:0] REQ_BAD_HI = 3'd7;

  typedef enum int {RX_FREE, RX_COIN, RX_PATTERN, RX_STARVED} rx_mode_e;

  typedef struct packed {
    logic [REQ_W-1:0] req;
    logic [POS_W-1:0] src_x;
    logic [POS_W-1:0] src_y;
    logic [RW_W-1:0]  rect_w;
    logic [RH_W-1:0]  rect_h;
    logic [POS_W-1:0] dst_x;
    logic [POS_W-1:0] dst_y;
    logic [PIX_W-1:0] pix;
  } blit_cmd_t;

  typedef struct packed {
    st_e              st;
    logic [PIX_W-1:0] pix;
  } blit_resp_t;

  logic                  clk_i;
  logic                  rst_ni = 1'b0;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  blit_cmd_t             tx_cmd = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [ST_W-1:0]       status;
  logic [PIX_W-1:0]      pixel_out;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // shadow of the block: frame store, halt flag, frame size
  bit [PIX_W-1:0]  shadow_px [STORE_DEPTH];
  bit              shadow_halt = 1'b0;
  logic [RW_W-1:0] shadow_fw = FRAME_WIDTH_RST;
  logic [RH_W-1:0] shadow_fh = FRAME_HEIGHT_RST;

  blit_cmd_t  pending_cmds[$];
  blit_resp_t expected_resps[$];

  int       burst_left;
  int       gap_left;
  rx_mode_e rx_mode;
  int       rx_left;
  int       rx_phase;
  int       rx_hold_req;
  int       rx_hold_seen;
  int       rx_hold_left;
  int       mismatches;
  int       idle_cycles;

  rgb_frame_block_copy_swap_mirror_core dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (tx_cmd.req),
    .src_x_i       (tx_cmd.src_x),
    .src_y_i       (tx_cmd.src_y),
    .rect_width_i  (tx_cmd.rect_w),
    .rect_height_i (tx_cmd.rect_h),
    .dst_x_i       (tx_cmd.dst_x),
    .dst_y_i       (tx_cmd.dst_y),
    .pixel_in_i    (tx_cmd.pix),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .pixel_out_o   (pixel_out),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_data_i    (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  function automatic int live_w();
    return (shadow_fw > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(shadow_fw);
  endfunction

  function automatic int live_h();
    return (shadow_fh > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(shadow_fh);
  endfunction

  function automatic bit on_frame(int x, int y);
    return x >= 0 && x < live_w() && y >= 0 && y < live_h();
  endfunction

  function automatic int px_addr(int x, int y);
    return y * live_w() + x;
  endfunction

  function automatic void swap_px(int a, int b);
    bit [PIX_W-1:0] t;
    t = shadow_px[a];
    shadow_px[a] = shadow_px[b];
    shadow_px[b] = t;
  endfunction

  // column by column, each pixel checked just before it moves
  function automatic st_e move_rect(bit do_swap, int sx, int sy, int w, int h,
                                    int dx, int dy);
    for (int xi = 0; xi < w; xi++) begin
      for (int yi = 0; yi < h; yi++) begin
        if (!on_frame(sx + xi, sy + yi) || !on_frame(dx + xi, dy + yi)) begin
          shadow_halt = 1'b1;
          return ST_RANGE;
        end
        if (do_swap)
          swap_px(px_addr(dx + xi, dy + yi), px_addr(sx + xi, sy + yi));
        else
          shadow_px[px_addr(dx + xi, dy + yi)] = shadow_px[px_addr(sx + xi, sy + yi)];
      end
    end
    return ST_OK;
  endfunction

  function automatic void mirror_rows();
    int w;
    int h;
    w = live_w();
    h = live_h();
    for (int x = 0; x < w; x++)
      for (int y = 0; y < h / 2; y++)
        swap_px(px_addr(x, y), px_addr(x, h - y - 1));
  endfunction

  function automatic void mirror_cols();
    int w;
    int h;
    w = live_w();
    h = live_h();
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w / 2; x++)
        swap_px(px_addr(x, y), px_addr(w - x - 1, y));
  endfunction

  function automatic blit_resp_t predict_resp(blit_cmd_t c);
    blit_resp_t r;
    int sx;
    int sy;
    int dx;
    int dy;
    r.st = ST_OK;
    r.pix = '0;
    sx = int'($signed(c.src_x));
    sy = int'($signed(c.src_y));
    dx = int'($signed(c.dst_x));
    dy = int'($signed(c.dst_y));
    case (c.req)
      REQ_WRITE, REQ_READ: begin
        if (!on_frame(sx, sy))
          r.st = ST_RANGE;
        else if (c.req == REQ_WRITE)
          shadow_px[px_addr(sx, sy)] = c.pix;
        else
          r.pix = shadow_px[px_addr(sx, sy)];
      end
      REQ_COPY, REQ_SWAP, REQ_MIRROR_TB, REQ_MIRROR_LR: begin
        if (shadow_halt)
          r.st = ST_HALTED;
        else if (c.req == REQ_MIRROR_TB)
          mirror_rows();
        else if (c.req == REQ_MIRROR_LR)
          mirror_cols();
        else
          r.st = move_rect(c.req == REQ_SWAP, sx, sy, int'(c.rect_w), int'(c.rect_h),
                           dx, dy);
      end
      default: r.st = ST_RANGE;
    endcase
    return r;
  endfunction

  function automatic void flag_mismatch(string what, logic [31:0] want, logic [31:0] got);
    mismatches++;
    if (mismatches <= 10)
      $display("tb: mismatch on %s: expected %0h, got %0h", what, want, got);
  endfunction

  function automatic void send(logic [REQ_W-1:0] req, int sx, int sy, int rw, int rh,
                               int dx, int dy, logic [PIX_W-1:0] pix);
    blit_cmd_t c;
    c.req    = req;
    c.src_x  = POS_W'(sx);
    c.src_y  = POS_W'(sy);
    c.rect_w = RW_W'(rw);
    c.rect_h = RH_W'(rh);
    c.dst_x  = POS_W'(dx);
    c.dst_y  = POS_W'(dy);
    c.pix    = pix;
    pending_cmds.push_back(c);
  endfunction

  // driver: bursts of beats with random gaps, payload held until taken
  always @(posedge clk_i or negedge rst_ni) begin
    logic held;
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_cmd <= '0;
      burst_left = 0;
      gap_left = 0;
    end else begin
      held = in_valid;
      if (in_valid && in_ready) begin
        expected_resps.push_back(predict_resp(tx_cmd));
        held = 1'b0;
      end
      if (!held) begin
        if (burst_left == 0 && gap_left == 0) begin
          burst_left = $urandom_range(1, 40);
          gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 15);
        end
        if (burst_left > 0 && pending_cmds.size() > 0) begin
          tx_cmd <= pending_cmds.pop_front();
          in_valid <= 1'b1;
          burst_left--;
        end else begin
          in_valid <= 1'b0;
          if (burst_left == 0)
            gap_left--;
        end
      end
    end
  end

  // monitor: check each result beat, then pick the next ready level
  always @(posedge clk_i or negedge rst_ni) begin
    blit_resp_t want;
    logic rdy;
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_left = 0;
      rx_hold_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_resps.size() == 0) begin
          flag_mismatch("result with nothing expected", '0, {status, pixel_out});
        end else begin
          want = expected_resps.pop_front();
          if (status !== want.st)
            flag_mismatch("status", want.st, status);
          if (pixel_out !== want.pix)
            flag_mismatch("pixel_out", want.pix, pixel_out);
        end
      end
      if (rx_hold_seen != rx_hold_req) begin
        rx_hold_seen = rx_hold_req;
        rx_hold_left = RX_HOLD_CYCLES;
      end
      if (rx_left == 0) begin
        rx_mode = rx_mode_e'($urandom_range(0, 3));
        rx_left = $urandom_range(16, 160);
      end
      rx_left--;
      rx_phase++;
      case (rx_mode)
        RX_FREE:    rdy = 1'b1;
        RX_COIN:    rdy = 1'($urandom_range(0, 1));
        RX_PATTERN: rdy = (rx_phase % 5) < 3;
        default:    rdy = ($urandom_range(0, 7) == 0);
      endcase
      if (rx_hold_left > 0) begin
        rdy = 1'b0;
        rx_hold_left--;
      end
      out_ready <= rdy;
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid && in_ready) || (out_valid && out_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: done, errors");
      $finish;
    end
  end

  task automatic drain();
    @(negedge clk_i);
    while (pending_cmds.size() != 0 || in_valid || expected_resps.size() != 0)
      @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  task automatic set_frame(input int w, input int h);
    drain();
    @(posedge clk_i);
    cfg_we <= 1'b1;
    cfg_idx <= CFG_FRAME_WIDTH;
    cfg_data <= CFG_DATA_W'(w);
    @(posedge clk_i);
    cfg_idx <= CFG_FRAME_HEIGHT;
    cfg_data <= CFG_DATA_W'(h);
    @(posedge clk_i);
    cfg_we <= 1'b0;
    shadow_fw = RW_W'(w);
    shadow_fh = RH_W'(h);
    @(negedge clk_i);
  endtask

  task automatic load_frame(input int w, input int h);
    for (int y = 0; y < h; y++)
      for (int x = 0; x < w; x++)
        send(REQ_WRITE, x, y, $urandom, $urandom, $urandom, $urandom, PIX_W'($urandom));
  endtask

  // mostly in-frame traffic on a loaded frame, with some noise
  task automatic random_ops(input int w, input int h, input int n);
    int pick;
    int rw;
    int rh;
    int x;
    int y;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 99);
      rw = $urandom_range(1, w);
      rh = $urandom_range(1, h);
      if (pick < 25) begin
        send(REQ_WRITE, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
             $urandom, $urandom, $urandom, $urandom, PIX_W'($urandom));
      end else if (pick < 45) begin
        send(REQ_READ, $urandom_range(0, w - 1), $urandom_range(0, h - 1),
             $urandom, $urandom, $urandom, $urandom, PIX_W'($urandom));
      end else if (pick < 80) begin
        send((pick < 63) ? REQ_COPY : REQ_SWAP,
             $urandom_range(0, w - rw), $urandom_range(0, h - rh), rw, rh,
             $urandom_range(0, w - rw), $urandom_range(0, h - rh), PIX_W'($urandom));
      end else if (pick < 90) begin
        send((pick < 85) ? REQ_MIRROR_TB : REQ_MIRROR_LR,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             PIX_W'($urandom));
      end else if (pick < 93) begin
        // empty rectangle with wild corners
        if ($urandom_range(0, 1))
          send($urandom_range(0, 1) ? REQ_COPY : REQ_SWAP,
               $urandom, $urandom, 0, $urandom, $urandom, $urandom, PIX_W'($urandom));
        else
          send($urandom_range(0, 1) ? REQ_COPY : REQ_SWAP,
               $urandom, $urandom, $urandom, 0, $urandom, $urandom, PIX_W'($urandom));
      end else if (pick < 97) begin
        do begin
          x = int'($signed(POS_W'($urandom)));
          y = int'($signed(POS_W'($urandom)));
        end while (x >= 0 && x < w && y >= 0 && y < h);
        send($urandom_range(0, 1) ? REQ_WRITE : REQ_READ, x, y,
             $urandom, $urandom, $urandom, $urandom, PIX_W'($urandom));
      end else begin
        send($urandom_range(0, 1) ? REQ_BAD_LO : REQ_BAD_HI,
             $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
             PIX_W'($urandom));
      end
    end
  endtask

  initial begin
    int w;
    int h;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // corners of the reset-size frame and just outside it
    send(REQ_WRITE, 0, 0, 0, 0, 0, 0, 24'h000000);
    send(REQ_WRITE, 639, 479, -1, -1, -1, -1, 24'hFFFFFF);
    send(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_READ, 639, 479, 0, 0, 0, 0, 0);
    send(REQ_WRITE, -1, 0, 0, 0, 0, 0, 24'h123456);
    send(REQ_WRITE, 640, 0, 0, 0, 0, 0, 24'h654321);
    send(REQ_READ, 0, 480, 0, 0, 0, 0, 0);
    send(REQ_READ, -2048, 2047, 0, 0, 0, 0, 0);
    send(REQ_WRITE, 2047, -2048, 0, 0, 0, 0, 24'hFFFFFF);
    send(REQ_BAD_LO, -1, -1, -1, -1, -1, -1, 24'hFFFFFF);
    send(REQ_BAD_HI, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_COPY, -2048, 2047, 0, 1023, 2047, -2048, 0);
    send(REQ_SWAP, 2047, 2047, 2047, 0, -2048, -2048, 0);

    // largest frame, then oversized values that saturate to it
    set_frame(MAX_WIDTH_DEF, MAX_HEIGHT_DEF);
    send(REQ_WRITE, 1023, 511, 0, 0, 0, 0, 24'hA5A5A5);
    send(REQ_READ, 1023, 511, 0, 0, 0, 0, 0);
    send(REQ_WRITE, 1024, 0, 0, 0, 0, 0, 24'h111111);
    send(REQ_READ, 0, 512, 0, 0, 0, 0, 0);
    set_frame(2047, 1023);
    send(REQ_READ, 1023, 511, 0, 0, 0, 0, 0);
    send(REQ_WRITE, 1023, 511, 0, 0, 0, 0, 24'h5A5A5A);
    send(REQ_READ, 1023, 511, 0, 0, 0, 0, 0);
    send(REQ_READ, 2047, 1023, 0, 0, 0, 0, 0);

    // zero-sized frame: mirrors move nothing, every pixel is outside
    set_frame(0, 5);
    send(REQ_MIRROR_TB, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_MIRROR_LR, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_WRITE, 0, 0, 0, 0, 0, 0, 24'h00FF00);
    send(REQ_COPY, 0, 0, 0, 3, 0, 0, 0);
    set_frame(7, 0);
    send(REQ_MIRROR_TB, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_MIRROR_LR, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_READ, 0, 0, 0, 0, 0, 0, 0);

    // odd-sized frame: overlapping copy and swap, both mirrors
    set_frame(5, 3);
    load_frame(5, 3);
    send(REQ_COPY, 0, 0, 3, 2, 1, 1, 0);
    send(REQ_SWAP, 0, 0, 2, 3, 1, 0, 0);
    send(REQ_MIRROR_TB, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_MIRROR_LR, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_READ, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_READ, 2, 1, 0, 0, 0, 0, 0);
    send(REQ_READ, 4, 2, 0, 0, 0, 0, 0);

    for (int p = 0; p < RAND_PHASES; p++) begin
      case (p)
        0: begin w = 1;  h = 1;  end
        1: begin w = 16; h = 1;  end
        2: begin w = 1;  h = 16; end
        3: begin w = 16; h = 16; end
        default: begin
          w = $urandom_range(2, 12);
          h = $urandom_range(2, 12);
        end
      endcase
      set_frame(w, h);
      load_frame(w, h);
      // hold off the receiver while the load is still being offered
      if (p == 3)
        rx_hold_req <= rx_hold_req + 1;
      random_ops(w, h, OPS_PER_PHASE);
    end

    // swap runs off the right edge after three columns: moved pixels stay, halt latches
    set_frame(8, 6);
    load_frame(8, 6);
    send(REQ_SWAP, 5, 0, 4, 2, 1, 3, 0);
    send(REQ_COPY, 0, 0, 1, 1, 0, 0, 0);
    send(REQ_SWAP, 0, 0, 1, 1, 1, 1, 0);
    send(REQ_MIRROR_TB, 0, 0, 0, 0, 0, 0, 0);
    send(REQ_MIRROR_LR, 0, 0, 0, 0, 0, 0, 0);
    for (int y = 0; y < 6; y++)
      for (int x = 0; x < 8; x++)
        send(REQ_READ, x, y, 0, 0, 0, 0, 0);
    for (int i = 0; i < OPS_PER_PHASE; i++) begin
      if ($urandom_range(0, 1))
        send(REQ_W'($urandom_range(0, 7)), $urandom, $urandom, $urandom, $urandom,
             $urandom, $urandom, PIX_W'($urandom));
      else
        send($urandom_range(0, 1) ? REQ_WRITE : REQ_READ,
             $urandom_range(0, 7), $urandom_range(0, 5),
             $urandom, $urandom, $urandom, $urandom, PIX_W'($urandom));
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (mismatches == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
